### hw/rtl/fia_pkg.sv
// Shared opcodes, field widths and controller/datapath handshake structs.
package fia_pkg;

  localparam int OPCODE_W  = 3;
  localparam int REG_SEL_W = 2;
  localparam int IMM_W     = 32;
  localparam int OUT_W     = 32;

  localparam logic [OPCODE_W-1:0] OP_IN  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_MOV = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_ADD = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_SUB = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_MUL = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_DIV = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_OUT = 3'd6;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // latch instruction, read operands
    logic wr_simple;   // write back IN/MOV/ADD/SUB result
    logic iter_start;  // load multiply/divide working registers
    logic iter_step;   // one shift-add / restoring-divide step
    logic wr_iter;     // write back multiply/divide result
    logic out_load;    // load the result register for OUT
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_iter;
    logic is_out;
    logic out_full;
  } status_t;

endpackage

### hw/rtl/fia_in_if.sv
// Instruction channel: valid/ready with the instruction payload.
interface fia_in_if;
  logic                          valid;
  logic                          ready;
  logic [fia_pkg::OPCODE_W-1:0]  opcode;
  logic [fia_pkg::REG_SEL_W-1:0] dest_reg;
  logic [fia_pkg::REG_SEL_W-1:0] src_reg;
  logic signed [fia_pkg::IMM_W-1:0] immediate;

  modport source (output valid, opcode, dest_reg, src_reg, immediate, input ready);
  modport sink   (input valid, opcode, dest_reg, src_reg, immediate, output ready);
endinterface

### hw/rtl/fia_out_if.sv
// Result channel: valid/ready with the reported register value.
interface fia_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [fia_pkg::OUT_W-1:0] out_value;

  modport source (output valid, out_value, input ready);
  modport sink   (input valid, out_value, output ready);
endinterface

### hw/rtl/four_register_alu_interpreter_core.sv
// Top level of the four-register instruction interpreter.
//
//  channel  | dir | beat payload
//  ---------+-----+----------------------------------------------
//  in_i     | in  | opcode, dest_reg, src_reg, immediate
//  out_o    | out | out_value (one beat per OUT instruction)
//
// IN, MOV, ADD, SUB and unused opcodes go through accept, then register-file read and
// write back. OUT waits after accept while the result register is full.
// MUL and DIV pass through accept, working-register load, the one-bit-per-cycle shift-add /
// restoring unit and write back. One instruction is in flight at a time.
// Reset clears control state and marks all registers as zero at once.
module four_register_alu_interpreter_core #(
  parameter int DATA_WIDTH = 32,
  parameter int NUM_REGS   = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fia_in_if.sink     in_i,
  fia_out_if.source  out_o
);
  import fia_pkg::*;

  cmd_t    cmd;
  status_t status;

  fia_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fia_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .NUM_REGS   (NUM_REGS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .opcode_i    (in_i.opcode),
    .dest_reg_i  (in_i.dest_reg),
    .src_reg_i   (in_i.src_reg),
    .immediate_i (in_i.immediate),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_value_o (out_o.out_value)
  );

  // one instruction at a time
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("instruction accepted in the cycle after an accept");

  // a result beat appears only from an OUT instruction
  a_out_from_out_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.out_load) && $past(status.is_out))
    else $error("result beat without an OUT instruction");

  // never overwrite a pending result
  a_no_out_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !status.out_full)
    else $error("result register loaded while full");

  // multiply/divide keeps the input closed while iterating
  a_iter_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.iter_start |=> !in_i.ready ##1 !in_i.ready)
    else $error("input opened during multiply/divide");

endmodule

### hw/rtl/fia_ctrl.sv
// Instruction sequencer: fetch, simple execute, iterative execute, write back.
module fia_ctrl #(
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fia_pkg::status_t status_i,
  output fia_pkg::cmd_t    cmd_o
);
  import fia_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_ITER  = 2'd2;
  localparam logic [1:0] S_WB    = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_FETCH;
        end
      end
      S_FETCH: begin
        priority if (status_i.is_out) begin
          // hold until the previous result beat has left
          if (!status_i.out_full) begin
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else if (status_i.is_iter) begin
          cmd_o.iter_start = 1'b1;
          cnt_d            = '0;
          state_d          = S_ITER;
        end else begin
          cmd_o.wr_simple = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_ITER: begin
        cmd_o.iter_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wr_iter = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### hw/rtl/fia_dp.sv
// Register file, ALU, shift-add multiplier, restoring divider, result register.
module fia_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int NUM_REGS   = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fia_pkg::cmd_t                        cmd_i,
  output fia_pkg::status_t                     status_o,
  input  logic [fia_pkg::OPCODE_W-1:0]         opcode_i,
  input  logic [fia_pkg::REG_SEL_W-1:0]        dest_reg_i,
  input  logic [fia_pkg::REG_SEL_W-1:0]        src_reg_i,
  input  logic signed [fia_pkg::IMM_W-1:0]     immediate_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [fia_pkg::OUT_W-1:0]     out_value_o
);
  import fia_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int IDX_W = $clog2(NUM_REGS);

  // latched instruction
  logic [OPCODE_W-1:0]  op_q;
  logic [REG_SEL_W-1:0] dst_q, src_q;
  logic [IMM_W-1:0]     imm_q;

  // register file; entries read as zero until first written
  logic [W-1:0]        mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid_q;

  logic [REG_SEL_W-1:0] sel_a, sel_b;
  logic [IDX_W-1:0]     idx_a, idx_b, idx_w;
  logic                 ok_a, ok_b, ok_w;
  logic [W-1:0]         opa_q, opb_q;

  logic         wr_en;
  logic [W-1:0] wr_data;

  // iterative unit
  logic [W-1:0] acc_q, x_q, y_q;
  logic         neg_q, dz_q;
  logic [W:0]   rem_sh, rem_diff;
  logic [W-1:0] mag_a, mag_b;

  logic                 out_valid_q;
  logic [OUT_W-1:0]     out_value_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= opcode_i;
      dst_q <= dest_reg_i;
      src_q <= src_reg_i;
      imm_q <= immediate_i;
    end
  end

  assign sel_a = cmd_i.accept ? dest_reg_i : dst_q;
  assign sel_b = cmd_i.accept ? src_reg_i  : src_q;
  assign ok_a  = 32'(sel_a) < NUM_REGS;
  assign ok_b  = 32'(sel_b) < NUM_REGS;
  assign ok_w  = 32'(dst_q) < NUM_REGS;
  assign idx_a = IDX_W'(sel_a);
  assign idx_b = IDX_W'(sel_b);
  assign idx_w = IDX_W'(dst_q);

  always_ff @(posedge clk_i) begin
    opa_q <= (ok_a && valid_q[idx_a]) ? mem[idx_a] : '0;
    opb_q <= (ok_b && valid_q[idx_b]) ? mem[idx_b] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && ok_w) begin
      mem[idx_w] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en && ok_w) begin
      valid_q[idx_w] <= 1'b1;
    end
  end

  // write-back selection
  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    if (cmd_i.wr_simple) begin
      unique case (op_q)
        OP_IN: begin
          wr_en   = 1'b1;
          wr_data = W'($signed(imm_q));
        end
        OP_MOV: begin
          wr_en   = 1'b1;
          wr_data = opb_q;
        end
        OP_ADD: begin
          wr_en   = 1'b1;
          wr_data = opa_q + opb_q;
        end
        OP_SUB: begin
          wr_en   = 1'b1;
          wr_data = opa_q - opb_q;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end else if (cmd_i.wr_iter) begin
      if (op_q == OP_MUL) begin
        wr_en   = 1'b1;
        wr_data = acc_q;
      end else begin
        // zero divisor leaves the destination alone
        wr_en   = !dz_q;
        wr_data = neg_q ? (~x_q + 1'b1) : x_q;
      end
    end
  end

  assign mag_a    = opa_q[W-1] ? (~opa_q + 1'b1) : opa_q;
  assign mag_b    = opb_q[W-1] ? (~opb_q + 1'b1) : opb_q;
  assign rem_sh   = {acc_q, x_q[W-1]};
  assign rem_diff = rem_sh - {1'b0, y_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.iter_start) begin
      acc_q <= '0;
      neg_q <= opa_q[W-1] ^ opb_q[W-1];
      dz_q  <= (opb_q == '0);
      if (op_q == OP_MUL) begin
        x_q <= opa_q;
        y_q <= opb_q;
      end else begin
        x_q <= mag_a;
        y_q <= mag_b;
      end
    end else if (cmd_i.iter_step) begin
      if (op_q == OP_MUL) begin
        if (y_q[0]) begin
          acc_q <= acc_q + x_q;
        end
        x_q <= {x_q[W-2:0], 1'b0};
        y_q <= {1'b0, y_q[W-1:1]};
      end else begin
        // restoring step: quotient bits shift into x from the right
        x_q   <= {x_q[W-2:0], !rem_diff[W]};
        acc_q <= rem_diff[W] ? rem_sh[W-1:0] : rem_diff[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= OUT_W'(opa_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_value_o       = out_value_q;
  assign status_o.is_iter  = (op_q == OP_MUL) || (op_q == OP_DIV);
  assign status_o.is_out   = (op_q == OP_OUT);
  assign status_o.out_full = out_valid_q;

endmodule
